/* design/bbc_pkg.sv */
package bbc_pkg;

    localparam int MAX_SECTIONS   = 4;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 18;

    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
    localparam int COEF_WORD_BITS = 60;
    localparam int POLE_COEF_BITS = COEF_FRAC_BITS + 1;
    localparam int STATE_BITS     = 32;
    localparam int COUNT_BITS     = 3;
    localparam int COEF_REGS      = 4;
    localparam int CFG_INDEX_BITS = $clog2(COEF_REGS + 3);
    localparam int CFG_DATA_BITS  = COEF_WORD_BITS;

    // headroom for every sum that is saturated afterwards
    localparam int ACC_BITS = ((SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS) + 6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SECTION_COUNT = CFG_INDEX_BITS'(COEF_REGS);
    localparam logic [CFG_INDEX_BITS-1:0] REG_POLE_ENABLE   = CFG_INDEX_BITS'(COEF_REGS + 1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_POLE_COEF     = CFG_INDEX_BITS'(COEF_REGS + 2);

    localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX =
        {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN =
        {{(ACC_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] STATE_MAX =
        {{(ACC_BITS - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] STATE_MIN =
        {{(ACC_BITS - STATE_BITS + 1){1'b1}}, {(STATE_BITS - 1){1'b0}}};

    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] sample;
    } bbc_link_t;

    typedef struct packed {
        logic clear;
        logic active;
    } bbc_cell_ctrl_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAMPLE_MAX)
        begin
            r = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end
        else if (v < SAMPLE_MIN)
        begin
            r = SAMPLE_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [STATE_BITS-1:0] r;
        if (v > STATE_MAX)
        begin
            r = STATE_MAX[STATE_BITS-1:0];
        end
        else if (v < STATE_MIN)
        begin
            r = STATE_MIN[STATE_BITS-1:0];
        end
        else
        begin
            r = v[STATE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* design/bbc_in_if.sv */
interface bbc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bbc_pkg::SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

/* design/bbc_out_if.sv */
interface bbc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bbc_pkg::SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

/* design/bbc_cfg_if.sv */
interface bbc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [bbc_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [bbc_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* design/bbc_biquad_cell.sv */
module bbc_biquad_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bbc_pkg::bbc_cell_ctrl_t              ctrl,
    input  logic [bbc_pkg::COEF_WORD_BITS-1:0]   coefs,
    input  bbc_pkg::bbc_link_t                   x_link,
    output bbc_pkg::bbc_link_t                   y_link,
    output logic                                 busy
);

    localparam int CB       = bbc_pkg::COEF_BITS;
    localparam int SB       = bbc_pkg::SAMPLE_BITS;
    localparam int FB       = bbc_pkg::COEF_FRAC_BITS;
    localparam int ZB       = bbc_pkg::STATE_BITS;
    localparam int AB       = bbc_pkg::ACC_BITS;
    localparam int MUL_BITS = CB + SB;
    localparam int DIF_BITS = MUL_BITS + 2;
    localparam int RND_BITS = DIF_BITS - FB;

    localparam logic signed [DIF_BITS-1:0] HALF = DIF_BITS'(1) << (FB - 1);

    typedef enum logic [4:0] {
        BQ_IDLE   = 5'b00001,
        BQ_SUM    = 5'b00010,
        BQ_MUL_A1 = 5'b00100,
        BQ_UPD_Z1 = 5'b01000,
        BQ_UPD_Z2 = 5'b10000
    } bq_state_t;

    bq_state_t state_reg;
    bq_state_t state_next;

    logic signed [CB-1:0]       b0;
    logic signed [CB-1:0]       a1;
    logic signed [CB-1:0]       a2;
    logic signed [CB-1:0]       mul_coef;
    logic signed [SB-1:0]       mul_data;
    logic signed [MUL_BITS-1:0] mul_out;
    logic signed [MUL_BITS-1:0] bx_reg;
    logic signed [MUL_BITS-1:0] prod_reg;
    logic signed [ZB-1:0]       z1_reg;
    logic signed [ZB-1:0]       z2_reg;
    logic signed [SB-1:0]       y_reg;
    logic                       y_valid_reg;

    logic signed [DIF_BITS-1:0] bx_w;
    logic signed [DIF_BITS-1:0] prod_w;
    logic signed [DIF_BITS-1:0] y_dif;
    logic signed [DIF_BITS-1:0] z1_dif;
    logic signed [DIF_BITS-1:0] z2_dif;
    logic signed [RND_BITS-1:0] y_rnd;
    logic signed [RND_BITS-1:0] z1_rnd;
    logic signed [RND_BITS-1:0] z2_rnd;
    logic signed [AB-1:0]       y_sum;
    logic signed [AB-1:0]       z1_sum;
    logic signed [AB-1:0]       z2_sum;
    logic                       start;

    assign b0 = coefs[CB-1:0];
    assign a1 = coefs[2*CB-1:CB];
    assign a2 = coefs[3*CB-1:2*CB];

    assign start = x_link.valid && (state_reg == BQ_IDLE);

    // one shared multiplier: b0*x on entry, then a1*y and a2*y
    always_comb
    begin
        mul_coef = a2;
        mul_data = y_reg;
        if (state_reg == BQ_IDLE)
        begin
            mul_coef = b0;
            mul_data = x_link.sample;
        end
        else if (state_reg == BQ_MUL_A1)
        begin
            mul_coef = a1;
        end
    end

    assign mul_out = mul_coef * mul_data;

    // round half up, floor shift back to sample scale
    assign bx_w   = DIF_BITS'(bx_reg);
    assign prod_w = DIF_BITS'(prod_reg);
    assign y_dif  = bx_w + HALF;
    assign z1_dif = (bx_w <<< 1) - prod_w + HALF;
    assign z2_dif = bx_w - prod_w + HALF;
    assign y_rnd  = $signed(y_dif[DIF_BITS-1:FB]);
    assign z1_rnd = $signed(z1_dif[DIF_BITS-1:FB]);
    assign z2_rnd = $signed(z2_dif[DIF_BITS-1:FB]);
    assign y_sum  = AB'(z1_reg) + AB'(y_rnd);
    assign z1_sum = AB'(z1_rnd) + AB'(z2_reg);
    assign z2_sum = AB'(z2_rnd);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BQ_IDLE:
            begin
                if (x_link.valid && ctrl.active)
                begin
                    state_next = BQ_SUM;
                end
            end
            BQ_SUM:    state_next = BQ_MUL_A1;
            BQ_MUL_A1: state_next = BQ_UPD_Z1;
            BQ_UPD_Z1: state_next = BQ_UPD_Z2;
            BQ_UPD_Z2: state_next = BQ_IDLE;
            default:   state_next = BQ_IDLE;
        endcase
        if (ctrl.clear)
        begin
            state_next = BQ_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BQ_IDLE;
            y_valid_reg <= 1'b0;
            z1_reg      <= '0;
            z2_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            y_valid_reg <= 1'b0;
            if (ctrl.clear)
            begin
                z1_reg <= '0;
                z2_reg <= '0;
            end
            else
            begin
                // an unused section hands the sample straight on
                if (start && !ctrl.active)
                begin
                    y_valid_reg <= 1'b1;
                end
                if (state_reg == BQ_SUM)
                begin
                    y_valid_reg <= 1'b1;
                end
                if (state_reg == BQ_UPD_Z1)
                begin
                    z1_reg <= bbc_pkg::sat_state(z1_sum);
                end
                if (state_reg == BQ_UPD_Z2)
                begin
                    z2_reg <= bbc_pkg::sat_state(z2_sum);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bx_reg <= mul_out;
            if (!ctrl.active)
            begin
                y_reg <= x_link.sample;
            end
        end
        if (state_reg == BQ_SUM)
        begin
            y_reg <= bbc_pkg::sat_sample(y_sum);
        end
        if (state_reg == BQ_MUL_A1 || state_reg == BQ_UPD_Z1)
        begin
            prod_reg <= mul_out;
        end
    end

    assign y_link.valid  = y_valid_reg;
    assign y_link.sample = y_reg;
    assign busy          = (state_reg != BQ_IDLE);

endmodule

/* design/bbc_pole_cell.sv */
module bbc_pole_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bbc_pkg::bbc_cell_ctrl_t              ctrl,
    input  logic [bbc_pkg::POLE_COEF_BITS-1:0]   coef,
    input  bbc_pkg::bbc_link_t                   x_link,
    output bbc_pkg::bbc_link_t                   y_link,
    output logic                                 busy
);

    localparam int SB        = bbc_pkg::SAMPLE_BITS;
    localparam int FB        = bbc_pkg::COEF_FRAC_BITS;
    localparam int ZB        = bbc_pkg::STATE_BITS;
    localparam int AB        = bbc_pkg::ACC_BITS;
    localparam int PB        = bbc_pkg::POLE_COEF_BITS;
    localparam int DIFF_BITS = ZB + 1;
    localparam int PROD_BITS = PB + 1 + DIFF_BITS;
    localparam int WIDE_BITS = PROD_BITS + 1;
    localparam int RND_BITS  = WIDE_BITS - FB;

    localparam logic [PB-1:0]               ONE  = PB'(1) << FB;
    localparam logic signed [WIDE_BITS-1:0] HALF = WIDE_BITS'(1) << (FB - 1);

    typedef enum logic [2:0] {
        PL_IDLE = 3'b001,
        PL_MUL  = 3'b010,
        PL_ACC  = 3'b100
    } pl_state_t;

    pl_state_t state_reg;
    pl_state_t state_next;

    logic signed [DIFF_BITS-1:0] diff_reg;
    logic [PB-1:0]               a_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [ZB-1:0]        z_reg;
    logic signed [SB-1:0]        y_reg;
    logic                        y_valid_reg;

    logic signed [WIDE_BITS-1:0] prod_w;
    logic signed [RND_BITS-1:0]  rnd;
    logic signed [AB-1:0]        z_sum;
    logic                        start;

    assign start  = x_link.valid && (state_reg == PL_IDLE);
    assign prod_w = WIDE_BITS'(prod_reg) + HALF;
    assign rnd    = $signed(prod_w[WIDE_BITS-1:FB]);
    assign z_sum  = AB'(z_reg) + AB'(rnd);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PL_IDLE:
            begin
                if (x_link.valid && ctrl.active)
                begin
                    state_next = PL_MUL;
                end
            end
            PL_MUL:  state_next = PL_ACC;
            PL_ACC:  state_next = PL_IDLE;
            default: state_next = PL_IDLE;
        endcase
        if (ctrl.clear)
        begin
            state_next = PL_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= PL_IDLE;
            y_valid_reg <= 1'b0;
            z_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            y_valid_reg <= 1'b0;
            if (ctrl.clear)
            begin
                z_reg <= '0;
            end
            else
            begin
                if (start && !ctrl.active)
                begin
                    y_valid_reg <= 1'b1;
                end
                if (state_reg == PL_ACC)
                begin
                    z_reg       <= bbc_pkg::sat_state(z_sum);
                    y_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            diff_reg <= DIFF_BITS'(x_link.sample) - DIFF_BITS'(z_reg);
            // a coefficient above one acts as exactly one
            a_reg    <= (coef > ONE) ? ONE : coef;
            if (!ctrl.active)
            begin
                y_reg <= x_link.sample;
            end
        end
        if (state_reg == PL_MUL)
        begin
            prod_reg <= $signed({1'b0, a_reg}) * diff_reg;
        end
        if (state_reg == PL_ACC)
        begin
            y_reg <= bbc_pkg::sat_sample(z_sum);
        end
    end

    assign y_link.valid  = y_valid_reg;
    assign y_link.sample = y_reg;
    assign busy          = (state_reg != PL_IDLE);

endmodule

/* design/butterworth_biquad_cascade_core.sv */
// A sample runs through the section cells and then the one-pole stage (N = sections in
// use, at most 4, taken by the first N cells): an unused cell or a disabled one-pole stage
// hands the sample straight on, a used section gives its result from state BQ_SUM and
// the one-pole stage from PL_ACC, and the result is registered at the output. One sample is
// in flight; a new one is taken only once its result is stored and every cell is idle. Reset
// clears coefficients, counts and all filter state; a write to a known index clears the state.
module butterworth_biquad_cascade_core (
    input  logic          clk,
    input  logic          rst_n,
    bbc_in_if.sink        samples,
    bbc_out_if.source     filtered,
    bbc_cfg_if.sink       cfg
);

    localparam int NS = bbc_pkg::MAX_SECTIONS;
    localparam int CW = bbc_pkg::COUNT_BITS;

    logic [bbc_pkg::COEF_WORD_BITS-1:0]  coefs_reg [NS];
    logic [CW-1:0]                       section_count_reg;
    logic                                pole_enable_reg;
    logic [bbc_pkg::POLE_COEF_BITS-1:0]  pole_coef_reg;

    logic                                busy_reg;
    logic                                busy_next;
    logic                                pend_reg;
    logic                                pend_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [bbc_pkg::SAMPLE_BITS-1:0] out_data_reg;

    logic                                in_fire;
    logic                                cfg_fire;
    logic                                chain_idle;
    logic                                state_clear;
    logic                                load;
    logic [CW:0]                         count_eff;
    logic [NS-1:0]                       cell_busy;
    logic                                pole_busy;
    logic [NS:0]                         link_valid;

    bbc_pkg::bbc_link_t                  links [NS+1];
    bbc_pkg::bbc_link_t                  pole_out;
    bbc_pkg::bbc_cell_ctrl_t             cell_ctrl [NS];
    bbc_pkg::bbc_cell_ctrl_t             pole_ctrl;

    assign chain_idle  = !busy_reg && !(|cell_busy) && !pole_busy;

    // hold register writes until no sample is in flight
    assign cfg.ready   = chain_idle;
    assign cfg_fire    = cfg.valid && cfg.ready;
    // writes to unknown indexes are dropped and keep the state
    assign state_clear = cfg_fire && (cfg.index <= bbc_pkg::REG_POLE_COEF);

    // an offered register write goes first
    assign samples.ready = chain_idle && !cfg.valid;
    assign in_fire       = samples.valid && samples.ready;

    assign count_eff = ({1'b0, section_count_reg} > (CW + 1)'(NS)) ?
                       (CW + 1)'(NS) : {1'b0, section_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                coefs_reg[k] <= '0;
            end
            section_count_reg <= '0;
            pole_enable_reg   <= 1'b0;
            pole_coef_reg     <= '0;
        end
        else if (cfg_fire)
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (k < bbc_pkg::COEF_REGS &&
                    cfg.index == bbc_pkg::CFG_INDEX_BITS'(k))
                begin
                    coefs_reg[k] <= cfg.data;
                end
            end
            if (cfg.index == bbc_pkg::REG_SECTION_COUNT)
            begin
                section_count_reg <= cfg.data[CW-1:0];
            end
            if (cfg.index == bbc_pkg::REG_POLE_ENABLE)
            begin
                pole_enable_reg <= cfg.data[0];
            end
            if (cfg.index == bbc_pkg::REG_POLE_COEF)
            begin
                pole_coef_reg <= cfg.data[bbc_pkg::POLE_COEF_BITS-1:0];
            end
        end
    end

    assign links[0].valid  = in_fire;
    assign links[0].sample = samples.sample_in;

    for (genvar k = 0; k < NS; k++)
    begin : g_cell
        assign cell_ctrl[k].clear  = state_clear;
        assign cell_ctrl[k].active = ((CW + 1)'(k) < count_eff);

        bbc_biquad_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (cell_ctrl[k]),
            .coefs  (coefs_reg[k]),
            .x_link (links[k]),
            .y_link (links[k+1]),
            .busy   (cell_busy[k])
        );

        assign link_valid[k] = links[k].valid;
    end

    assign pole_ctrl.clear  = state_clear;
    assign pole_ctrl.active = pole_enable_reg;

    bbc_pole_cell u_pole (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (pole_ctrl),
        .coef   (pole_coef_reg),
        .x_link (links[NS]),
        .y_link (pole_out),
        .busy   (pole_busy)
    );

    assign link_valid[NS] = links[NS].valid || pole_out.valid;

    // the pole cell holds its result until the next sample, so a pending result can wait there
    always_comb
    begin
        load           = (pole_out.valid || pend_reg) && (!out_valid_reg || filtered.ready);
        pend_next      = (pole_out.valid || pend_reg) && !load;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (filtered.ready)
        begin
            out_valid_next = 1'b0;
        end
        busy_next = busy_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
        end
        else if (load)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= pole_out.sample;
        end
    end

    assign filtered.valid      = out_valid_reg;
    assign filtered.sample_out = out_data_reg;

    a_pend_needs_full_output: assert property (
        @(posedge clk) disable iff (!rst_n) pend_reg |-> out_valid_reg
    ) else $error("pending result while the output register is empty");

    a_one_sample_in_chain: assert property (
        @(posedge clk) disable iff (!rst_n) $onehot0(link_valid)
    ) else $error("more than one sample moving through the cell chain");

    a_result_only_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n) pole_out.valid |-> (busy_reg && !pend_reg)
    ) else $error("chain result with no sample in flight or with one still pending");

    a_accept_sets_busy: assert property (
        @(posedge clk) disable iff (!rst_n) in_fire |=> (busy_reg && !samples.ready)
    ) else $error("input still open after a sample transfer");

endmodule
